// ----- sv/time_triggered_task_scheduler_unit_macros.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef TIME_TRIGGERED_TASK_SCHEDULER_UNIT_MACROS_SVH
`define TIME_TRIGGERED_TASK_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TTTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TTTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/ttts_pkg.sv -----
// Types and constants of the time-triggered task scheduler.
package ttts_pkg;

  localparam int NUM_TASKS_DEF   = 8;
  localparam int PERIOD_BITS_DEF = 16;
  localparam int MAX_REL         = 8;   // most releases one item can cause
  localparam int IDX_W           = 3;
  localparam int CNT_W           = 4;   // task_count and active slot count
  localparam int FIELD_W         = 16;  // period and offset fields
  localparam int PEND_W          = 16;
  localparam int OPCODE_W        = 2;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD     = 2'd0,
    OP_TICK     = 2'd1,
    OP_DISPATCH = 2'd2
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYBRID     = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                inject;     // put the walk token into cell 0
    logic                step;       // token holder updates, token moves on
    logic                last_step;  // token holder is the last active slot
    logic                is_tick;
    logic                hybrid;
    logic                load_en;
    logic [IDX_W-1:0]    load_slot;
    logic [FIELD_W-1:0]  load_period;
    logic [FIELD_W-1:0]  load_offset;
    logic                load_mode;
  } cell_ctl_t;

endpackage

// ----- sv/ttts_ifs.sv -----
// Valid/ready channel interfaces for scheduler items and releases.
interface ttts_in_if;
  import ttts_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [IDX_W-1:0]    slot;
  logic [FIELD_W-1:0]  period;
  logic [FIELD_W-1:0]  offset;
  logic                tick_mode;
  modport source(output valid, opcode, slot, period, offset, tick_mode, input ready);
  modport sink(input valid, opcode, slot, period, offset, tick_mode, output ready);
endinterface

interface ttts_out_if;
  import ttts_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] task_index;
  logic             from_tick;
  logic             last;
  modport source(output valid, task_index, from_tick, last, input ready);
  modport sink(input valid, task_index, from_tick, last, output ready);
endinterface

// ----- sv/ttts_cell.sv -----
// One task slot: countdown, reload period, release mode and walk token.
module ttts_cell #(
  parameter int PERIOD_BITS = ttts_pkg::PERIOD_BITS_DEF,
  parameter int CELL_IDX    = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ttts_pkg::cell_ctl_t ctl,
  input  logic                tok_in,
  output logic                tok_out,
  output logic                tok_held,
  output logic                rel_o
);
  import ttts_pkg::*;

  localparam int CW = PERIOD_BITS + 2;
  localparam logic [CW-1:0] FLOOR = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] ONE   = {{(CW-1){1'b0}}, 1'b1};

  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [PERIOD_BITS-1:0] per_r;
  logic                   mode_r;
  logic                   tok_r, tok_nxt;
  logic [CW-1:0]          cnt_dec;
  logic                   dec_le0, cur_le0, rel, load_hit;

  always_comb begin
    cnt_dec  = (cnt_r == FLOOR) ? cnt_r : cnt_r - ONE;  // saturate at the floor
    dec_le0  = cnt_dec[CW-1] | (cnt_dec == '0);
    cur_le0  = cnt_r[CW-1] | (cnt_r == '0);
    load_hit = ctl.load_en && (int'(ctl.load_slot) == CELL_IDX);
    if (ctl.is_tick) begin
      rel = ctl.hybrid & mode_r & dec_le0;
    end else begin
      rel = (!ctl.hybrid | !mode_r) & cur_le0;
    end
    rel_o    = tok_r & rel;
    tok_out  = tok_r & !ctl.last_step;
    tok_held = tok_r;
    tok_nxt  = (ctl.inject | ctl.step) ? tok_in : tok_r;

    cnt_nxt = cnt_r;
    if (load_hit) begin
      cnt_nxt = {2'b00, PERIOD_BITS'(ctl.load_offset)} + ONE;
    end else if (tok_r && ctl.step) begin
      if (rel) begin
        cnt_nxt = {2'b00, per_r};
      end else if (ctl.is_tick) begin
        cnt_nxt = cnt_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (load_hit) begin
      per_r  <= PERIOD_BITS'(ctl.load_period);
      mode_r <= ctl.load_mode;
    end
  end

endmodule

// ----- sv/ttts_seq.sv -----
// Sequencer: item intake, config registers, walk control, release buffer.
`include "time_triggered_task_scheduler_unit_macros.svh"
module ttts_seq #(
  parameter int NUM_TASKS = ttts_pkg::NUM_TASKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ttts_in_if.sink                             in_ch,
  ttts_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [ttts_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [ttts_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output ttts_pkg::cell_ctl_t                 ctl,
  input  logic                                rel_any
);
  import ttts_pkg::*;

  localparam int LIM = (NUM_TASKS < MAX_REL) ? NUM_TASKS : MAX_REL;
  localparam logic [CNT_W-1:0] LIM_C = CNT_W'(LIM);

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                have_r, have_nxt;
  logic [IDX_W-1:0]    buf_idx_r, buf_idx_nxt;
  logic                op_tick_r, op_tick_nxt;
  logic [PEND_W-1:0]   pend_r, pend_nxt;
  logic [CNT_W-1:0]    task_count_r;
  logic                hybrid_r;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic                out_tick_r, out_tick_nxt;
  logic                out_last_r, out_last_nxt;
  logic [CNT_W-1:0]    n_act;
  logic                last_step, out_free, in_acc;

  assign n_act        = (task_count_r > LIM_C) ? LIM_C : task_count_r;
  assign last_step    = (CNT_W'(idx_r) + CNT_W'(1)) == n_act;
  assign out_free     = !out_valid_r | out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid & in_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.task_index = out_idx_r;
  assign out_ch.from_tick  = out_tick_r;
  assign out_ch.last       = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    have_nxt      = have_r;
    buf_idx_nxt   = buf_idx_r;
    op_tick_nxt   = op_tick_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r & !out_ch.ready;
    out_idx_nxt   = out_idx_r;
    out_tick_nxt  = out_tick_r;
    out_last_nxt  = out_last_r;

    ctl             = '0;
    ctl.is_tick     = op_tick_r;
    ctl.hybrid      = hybrid_r;
    ctl.last_step   = last_step;
    ctl.load_slot   = in_ch.slot;
    ctl.load_period = in_ch.period;
    ctl.load_offset = in_ch.offset;
    ctl.load_mode   = in_ch.tick_mode;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.opcode)
            OP_LOAD: begin
              ctl.load_en = 1'b1;
            end
            OP_TICK: begin
              if (pend_r != '1) pend_nxt = pend_r + PEND_W'(1);
              op_tick_nxt = 1'b1;
              if (n_act != '0) begin
                ctl.inject = 1'b1;
                idx_nxt    = '0;
                state_nxt  = ST_WALK;
              end
            end
            OP_DISPATCH: begin
              if (pend_r != '0) begin
                pend_nxt    = '0;
                op_tick_nxt = 1'b0;
                if (n_act != '0) begin
                  ctl.inject = 1'b1;
                  idx_nxt    = '0;
                  state_nxt  = ST_WALK;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        // one slot per cycle; hold while the output register is blocked
        if (out_free) begin
          ctl.step = 1'b1;
          if (rel_any) begin
            if (have_r) begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = buf_idx_r;
              out_tick_nxt  = op_tick_r;
              out_last_nxt  = 1'b0;
            end
            buf_idx_nxt = idx_r;
            have_nxt    = 1'b1;
          end
          idx_nxt = idx_r + IDX_W'(1);
          if (last_step) state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!have_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = buf_idx_r;
          out_tick_nxt  = op_tick_r;
          out_last_nxt  = 1'b1;
          have_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      have_r       <= 1'b0;
      pend_r       <= '0;
      out_valid_r  <= 1'b0;
      task_count_r <= '0;
      hybrid_r     <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      have_r      <= have_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TASK_COUNT: task_count_r <= cfg_wdata;
          CFG_HYBRID:     hybrid_r     <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_idx_r  <= buf_idx_nxt;
    op_tick_r  <= op_tick_nxt;
    out_idx_r  <= out_idx_nxt;
    out_tick_r <= out_tick_nxt;
    out_last_r <= out_last_nxt;
  end

  `TTTS_ASSERT_IMP(a_idle_no_buf, state_r == ST_IDLE, !have_r, "held release while idle")
  `TTTS_ASSERT_IMP(a_walk_bound, state_r == ST_WALK, CNT_W'(idx_r) < n_act, "walk past slots")
  `TTTS_ASSERT_NXT(a_inject_walk, ctl.inject, state_r == ST_WALK, "token injected, no walk")
  `TTTS_ASSERT_NXT(a_dispatch_clr, in_acc && in_ch.opcode == OP_DISPATCH, pend_r == '0,
                   "dispatch left ticks pending")

endmodule

// ----- sv/time_triggered_task_scheduler_unit.sv -----
// Top level of the time-triggered task scheduler: sequencer and chain of slot cells.
//
// Input channel in_ch (valid/ready) takes items: load slot, timer tick or dispatch.
// Output channel out_ch (valid/ready) gives one item per task release: slot index,
// whether a tick or a dispatch released it, and last on the final release of an item.
// cfg_we/cfg_idx/cfg_wdata write task_count (index 0) and hybrid_enable (index 1);
// write them only while the block is idle.
// A load leaves the block idle. A tick or dispatch sends a token down the row of slot
// cells, one active slot per cycle while the output register is free, and holds
// the input until the walk ends; there are at most 8 active slots. A dispatch with
// no pending tick starts no walk.
// Each release is held one slot behind so that the last flag is known when the
// previous one is sent; the final one leaves from the closing state.
// When out_ch.ready is low with a result waiting, the token freezes in place
// and resumes when the output register frees.
// Reset clears the pending-tick count, sets task_count to 0 and hybrid_enable to 1;
// slot contents are undefined until loaded.
`include "time_triggered_task_scheduler_unit_macros.svh"
module time_triggered_task_scheduler_unit #(
  parameter int NUM_TASKS   = ttts_pkg::NUM_TASKS_DEF,
  parameter int PERIOD_BITS = ttts_pkg::PERIOD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ttts_in_if.sink                         in_ch,
  ttts_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ttts_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ttts_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ttts_pkg::*;

  cell_ctl_t            ctl;
  logic [NUM_TASKS-1:0] tok_out_vec;
  logic [NUM_TASKS-1:0] tok_vec;
  logic [NUM_TASKS-1:0] rel_vec;
  logic                 rel_any;

  // only the token holder can flag a release
  assign rel_any = |rel_vec;

  ttts_seq #(
    .NUM_TASKS(NUM_TASKS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .ctl      (ctl),
    .rel_any  (rel_any)
  );

  // token enters cell 0 and moves one cell per step
  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
    logic tok_in;
    if (g == 0) begin : g_head
      assign tok_in = ctl.inject;
    end else begin : g_link
      assign tok_in = tok_out_vec[g-1];
    end
    ttts_cell #(
      .PERIOD_BITS(PERIOD_BITS),
      .CELL_IDX   (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .tok_in  (tok_in),
      .tok_out (tok_out_vec[g]),
      .tok_held(tok_vec[g]),
      .rel_o   (rel_vec[g])
    );
  end

  `TTTS_ASSERT_IMP(a_tok_onehot, 1'b1, $onehot0(tok_vec), "more than one walk token")
  `TTTS_ASSERT_IMP(a_rel_token, rel_any, $onehot(tok_vec), "release with no token")

endmodule

// ----- sim/time_triggered_task_scheduler_unit_tb.sv -----
// Self-checking testbench for the time-triggered task scheduler: directed and random stimulus.
`timescale 1ns / 100ps

module time_triggered_task_scheduler_unit_tb;
  import ttts_pkg::*;

  // Opcode 3 has no meaning in the block; it must be swallowed silently.
  localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;

  // Active slots are capped by the table size and by the per-item release limit.
  localparam int NUM_SLOTS    = (NUM_TASKS_DEF < MAX_REL) ? NUM_TASKS_DEF : MAX_REL;
  // Countdowns are PERIOD_BITS+2 wide and signed; they stick at the most negative value.
  localparam int COUNT_FLOOR  = -(1 << (PERIOD_BITS_DEF + 1));
  localparam int unsigned PENDING_FULL = (1 << PEND_W) - 1;
  // A tick or dispatch walks at most 8 slots; leave some margin.
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [IDX_W-1:0]    slot;
    logic [FIELD_W-1:0]  period;
    logic [FIELD_W-1:0]  offset;
    logic                tick_mode;
  } sched_item_t;

  typedef struct {
    logic [IDX_W-1:0] task_index;
    logic             from_tick;
    logic             last;
  } release_t;

  // Tracks the task table, works out the releases each accepted item causes and
  // checks the block's releases against them in order.
  class release_tracker;
    int          countdown [NUM_SLOTS];
    int unsigned reload    [NUM_SLOTS];
    bit          by_tick   [NUM_SLOTS];
    int unsigned ticks_waiting;
    int unsigned task_count;
    bit          hybrid;
    release_t    awaited [$];
    int unsigned mismatches;
    int unsigned items_seen;
    int unsigned releases_seen;

    function new();
      ticks_waiting = 0;
      task_count    = 0;
      hybrid        = 1'b1;
      mismatches    = 0;
      items_seen    = 0;
      releases_seen = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_TASK_COUNT) task_count = data;
      else if (idx == CFG_HYBRID) hybrid = data[0];
    endfunction

    function void queue_release(int slot, bit tick);
      release_t r;
      r.task_index = IDX_W'(slot);
      r.from_tick  = tick;
      r.last       = 1'b0;
      awaited.push_back(r);
    endfunction

    function void note_item(sched_item_t it);
      int unsigned n;
      int          first;
      n     = (task_count > NUM_SLOTS) ? NUM_SLOTS : task_count;
      first = awaited.size();
      items_seen++;
      case (it.opcode)
        OP_LOAD: begin
          reload[it.slot]    = it.period;
          countdown[it.slot] = int'(it.offset) + 1;
          by_tick[it.slot]   = it.tick_mode;
        end
        OP_TICK: begin
          if (ticks_waiting < PENDING_FULL) ticks_waiting++;
          for (int i = 0; i < n; i++) begin
            if (countdown[i] > COUNT_FLOOR) countdown[i]--;
            if (hybrid && by_tick[i] && countdown[i] <= 0) begin
              countdown[i] = reload[i];
              queue_release(i, 1'b1);
            end
          end
        end
        OP_DISPATCH: begin
          if (ticks_waiting != 0) begin
            ticks_waiting = 0;
            for (int i = 0; i < n; i++) begin
              if ((!hybrid || !by_tick[i]) && countdown[i] <= 0) begin
                countdown[i] = reload[i];
                queue_release(i, 1'b0);
              end
            end
          end
        end
        default: ;
      endcase
      if (awaited.size() > first) awaited[awaited.size() - 1].last = 1'b1;
    endfunction

    function void check_release(release_t got);
      release_t want;
      releases_seen++;
      if (awaited.size() == 0) begin
        $error("release of slot %0d with none expected", got.task_index);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.task_index !== want.task_index) begin
        $error("task_index: expected %0d, got %0d", want.task_index, got.task_index);
        mismatches++;
      end
      if (got.from_tick !== want.from_tick) begin
        $error("from_tick: expected %0d, got %0d", want.from_tick, got.from_tick);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ttts_in_if  in_ch ();
  ttts_out_if out_ch ();

  // calm: no idling on either side. hold_off: receiver stall length, counted down
  // by the receiver process itself.
  bit calm = 1'b0;
  int hold_off = 0;

  release_tracker tracker = new();

  time_triggered_task_scheduler_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: ready changes on the falling edge. Random ~9% stalls, none while calm,
  // and a forced long stall when hold_off is loaded.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        hold_off--;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  // Release monitor: sample at the rising edge where the handshake completes.
  always @(posedge clk) begin
    release_t r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      r.task_index = out_ch.task_index;
      r.from_tick  = out_ch.from_tick;
      r.last       = out_ch.last;
      tracker.check_release(r);
    end
  end

  // Hard stop; far above the slowest legal run.
  initial begin
    #(2_000_000);
    $display("time_triggered_task_scheduler_unit regression: fail");
    $finish;
  end

  function automatic sched_item_t load_item(int slot, int period, int offset, bit mode);
    sched_item_t it;
    it.opcode    = OP_LOAD;
    it.slot      = IDX_W'(slot);
    it.period    = FIELD_W'(period);
    it.offset    = FIELD_W'(offset);
    it.tick_mode = mode;
    return it;
  endfunction

  // Tick, dispatch or the unused code; payload fields random, the block ignores them.
  function automatic sched_item_t op_item(logic [OPCODE_W-1:0] op);
    sched_item_t it;
    it.opcode    = op;
    it.slot      = IDX_W'($urandom);
    it.period    = FIELD_W'($urandom);
    it.offset    = FIELD_W'($urandom);
    it.tick_mode = 1'($urandom_range(1));
    return it;
  endfunction

  // Random mix: mostly short periods/offsets so releases are frequent, with an
  // occasional full-range value so every field bit toggles.
  function automatic sched_item_t random_item();
    int unsigned pick;
    int          per;
    int          off;
    pick = $urandom_range(99);
    if (pick < 30) begin
      per = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(6);
      off = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(4);
      return load_item($urandom_range(7), per, off, 1'($urandom_range(1)));
    end
    if (pick < 70) return op_item(OP_TICK);
    if (pick < 95) return op_item(OP_DISPATCH);
    return op_item(OP_RESERVED);
  endfunction

  // Offer one item; called and returns on a falling edge. The caller's next
  // drive (new item or valid low) lands in the same step as the return.
  task automatic send_item(sched_item_t it);
    if (!calm && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= it.opcode;
    in_ch.slot      <= it.slot;
    in_ch.period    <= it.period;
    in_ch.offset    <= it.offset;
    in_ch.tick_mode <= it.tick_mode;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_item(it);
    @(negedge clk);
  endtask

  // Drop valid, wait for every awaited release, then give the walk time to end.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write; only while idle.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.write_register(idx, CFG_DATA_W'(data));
    @(negedge clk);
  endtask

  task automatic random_phase(int unsigned slots, bit hybrid_on, int unsigned count);
    int unsigned done;
    sched_item_t it;
    settle();
    write_cfg(CFG_TASK_COUNT, slots);
    write_cfg(CFG_HYBRID, hybrid_on);
    done = 0;
    while (done < count) begin
      it = random_item();
      send_item(it);
      if (it.opcode != OP_RESERVED) done++;
    end
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_LOAD;
    in_ch.slot      = '0;
    in_ch.period    = '0;
    in_ch.offset    = '0;
    in_ch.tick_mode = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_TASK_COUNT;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- Directed part ----
    // Fill every slot first so no active slot is ever read unloaded. Mix covers
    // period zero, full-scale period/offset, both modes.
    send_item(load_item(0, 1, 0, 1'b1));
    send_item(load_item(1, 0, 0, 1'b0));          // period zero, dispatch mode
    send_item(load_item(2, 65535, 65535, 1'b1));  // extremes: never fires here
    send_item(load_item(3, 2, 1, 1'b0));
    send_item(load_item(4, 3, 0, 1'b1));
    send_item(load_item(5, 1, 2, 1'b0));
    send_item(load_item(6, 0, 0, 1'b1));          // period zero, tick mode
    send_item(load_item(7, 4, 3, 1'b0));
    send_item(op_item(OP_DISPATCH));              // nothing pending: no release
    send_item(op_item(OP_RESERVED));              // unused code: ignored

    settle();
    write_cfg(CFG_TASK_COUNT, NUM_SLOTS);         // hybrid still at its reset value
    send_item(op_item(OP_TICK));
    send_item(op_item(OP_TICK));
    send_item(op_item(OP_DISPATCH));              // two ticks pending, one pass
    send_item(op_item(OP_DISPATCH));              // pending already cleared
    send_item(op_item(OP_TICK));
    send_item(op_item(OP_RESERVED));
    send_item(op_item(OP_DISPATCH));

    // Hybrid off: tick-mode tasks fall through to dispatch.
    settle();
    write_cfg(CFG_HYBRID, 0);
    send_item(op_item(OP_TICK));
    send_item(op_item(OP_TICK));
    send_item(op_item(OP_DISPATCH));

    // task_count above the table size is clamped to 8 slots.
    settle();
    write_cfg(CFG_TASK_COUNT, 15);
    send_item(op_item(OP_TICK));
    send_item(op_item(OP_DISPATCH));

    // ---- Back-pressure ----
    // Every slot fires on every tick; the receiver holds off for a long stretch
    // while ticks keep coming, so the output fills and the input stalls.
    settle();
    write_cfg(CFG_HYBRID, 1);
    write_cfg(CFG_TASK_COUNT, NUM_SLOTS);
    for (int s = 0; s < NUM_SLOTS; s++) send_item(load_item(s, 0, 0, 1'b1));
    hold_off = 400;
    repeat (10) send_item(op_item(OP_TICK));
    send_item(op_item(OP_DISPATCH));
    repeat (4) send_item(op_item(OP_TICK));

    // ---- Random phases, config extremes included; first one without idling ----
    calm = 1'b1;
    random_phase(NUM_SLOTS, 1'b1, 50);
    calm = 1'b0;
    random_phase(1, 1'b0, 40);
    random_phase(0, 1'b1, 20);
    random_phase(15, 1'b0, 40);
    random_phase(5, 1'b1, 50);
    random_phase($urandom_range(1, NUM_SLOTS), 1'($urandom_range(1)), 50);
    random_phase($urandom_range(1, NUM_SLOTS), 1'($urandom_range(1)), 50);

    settle();
    if (tracker.awaited.size() != 0) begin
      $error("%0d expected releases never arrived", tracker.awaited.size());
      tracker.mismatches++;
    end
    $display("Covered %0d items and %0d releases: all opcodes, task_count 0 to 15,",
             tracker.items_seen, tracker.releases_seen);
    $display("hybrid on and off, period zero, full-range fields, output back-pressure.");
    if (tracker.mismatches == 0) begin
      $display("time_triggered_task_scheduler_unit regression: pass");
    end else begin
      $display("time_triggered_task_scheduler_unit regression: fail");
    end
    $finish;
  end

endmodule
